/* rtl/utce_pkg.sv */
// ============================================================================
// utce_pkg : shared constants, types and calendar helpers
// Calendar tables, leap-year test, mod-7 reduction and the per-stage
// payload records of the UTC date to epoch seconds pipeline.
// ============================================================================
package utce_pkg;

    // Time and calendar constants
    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_PER_DAY  = 24;
    localparam int MON_PER_YEAR  = 12;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_DAY   = 86400;
    localparam int DAYS_PER_YEAR = 365;
    localparam int EPOCH_YEAR    = 1970;
    localparam int LEAP4_BASE    = 1969;
    localparam int LEAP100_BASE  = 1901;
    localparam int LEAP400_BASE  = 1601;
    localparam int DAYS_PER_WEEK = 7;

    // Month codes
    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    // Reciprocals: floor(x*5243 >> 19) = x/100, >> 21 = x/400, for x < 4096
    localparam int RECIP_100    = 5243;
    localparam int SHIFT_100    = 19;
    localparam int SHIFT_400    = 21;

    // 7 * 2^17: lifts the signed day count to a non-negative weekday operand
    localparam int WDAY_LIFT    = 917504;
    // 2^32 mod 7, folded in when the 32-bit day count has wrapped
    localparam int WRAP_MOD7    = 4;
    // Thursday 1 January 1970
    localparam int EPOCH_WDAY   = 4;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
    } t_tod;

    // after field carries
    typedef struct packed {
        t_tod              tm;
        logic signed [5:0] day;    // zero-based, -1 means borrow
        logic [3:0]        month;
        logic [12:0]       year;
    } t_stage_a;

    // with leap flags and time of day in seconds
    typedef struct packed {
        t_tod              tm;
        logic [16:0]       tod;
        logic signed [5:0] day;
        logic [3:0]        month;
        logic [12:0]       year;
        logic              leap_cur;
        logic              leap_prev;
    } t_stage_b;

    // after month roll
    typedef struct packed {
        t_tod               tm;
        logic [16:0]        tod;
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day;   // zero-based
        logic               leap;
    } t_stage_c;

    // day of year and leap-count terms
    typedef struct packed {
        t_tod               tm;
        logic [16:0]        tod;
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [8:0]         yday;
        logic signed [10:0] q4;
        logic signed [6:0]  q100;
        logic signed [4:0]  q400;
        logic signed [20:0] m365;
    } t_stage_d;

    // signed day count
    typedef struct packed {
        t_tod               tm;
        logic [16:0]        tod;
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [8:0]         yday;
        logic signed [20:0] days;
        logic               invalid;
    } t_stage_e;

    // day seconds product and weekday operand
    typedef struct packed {
        t_tod               tm;
        logic [16:0]        tod;
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [8:0]         yday;
        logic               invalid;
        logic [31:0]        day_secs;
        logic [20:0]        wday_arg;
    } t_stage_f;

    // result beat
    typedef struct packed {
        logic [31:0] epoch;
        logic        invalid;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  min;
        logic [5:0]  sec;
        logic [8:0]  yday;
        logic [2:0]  wday;
    } t_stage_g;

    // Days before the first of each month, common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m) inside
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: r = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                  r = 5'd30;
            4'd1:                                     r = leap ? 5'd29 : 5'd28;
            default:                                  r = 5'd31;
        endcase
        return r;
    endfunction

    // Gregorian leap test; divisibility by 25 via 128 = 3 (mod 25)
    function automatic logic is_leap(input logic [12:0] y);
        logic [7:0] r;
        logic       div25;
        r = {1'b0, y[12:7], 1'b0} + {2'b0, y[12:7]} + {1'b0, y[6:0]};
        if (r >= 8'd200) r = r - 8'd200;
        if (r >= 8'd100) r = r - 8'd100;
        if (r >= 8'd50)  r = r - 8'd50;
        if (r >= 8'd25)  r = r - 8'd25;
        div25 = (r == 8'd0);
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    // x mod 7 via octal digit sum, since 8 = 1 (mod 7)
    function automatic logic [2:0] mod7(input logic [20:0] x);
        logic [5:0] s;
        logic [3:0] t;
        s = '0;
        for (int k = 0; k < 7; k++) begin
            s = s + {3'b0, x[3*k +: 3]};
        end
        t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
        if (t >= 4'(DAYS_PER_WEEK)) t = t - 4'(DAYS_PER_WEEK);
        return t[2:0];
    endfunction

endpackage

/* rtl/utc_date_to_epoch_seconds.sv */
// ============================================================================
// utc_date_to_epoch_seconds : broken-down UTC time to seconds since 1970
// Normalises the fields (leap seconds, day overflow and day zero), then
// gives day of year, weekday and epoch seconds modulo 2^32.
// ============================================================================
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------
//  input   | in        | i_valid / o_stall | year, month, day, hour, min, sec
//  result  | out       | o_valid / i_stall | epoch, invalid, normalised fields,
//          |           |                   | year day, weekday
//
//  One beat per clock while the result side does not stall; each beat reaches
//  o_valid through seven register stages (carries, leap test, month roll,
//  day of year and leap count, day count, day seconds product, final add).
//  Synchronous active-low reset clears the stage valid bits only.
//  A stall on the result side halts only the full stages behind it; empty
//  stages keep filling, so o_stall rises only when all seven are occupied.
//
module utc_date_to_epoch_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_epoch_seconds,
    output logic        o_invalid,
    output logic [11:0] o_norm_year,
    output logic [3:0]  o_norm_month,
    output logic [4:0]  o_norm_day,
    output logic [4:0]  o_norm_hour,
    output logic [5:0]  o_norm_minute,
    output logic [5:0]  o_norm_second,
    output logic [8:0]  o_year_day,
    output logic [2:0]  o_week_day
);

    localparam int NUM_STAGES = 7;
    localparam int ST_A = 0;
    localparam int ST_B = 1;
    localparam int ST_C = 2;
    localparam int ST_D = 3;
    localparam int ST_E = 4;
    localparam int ST_F = 5;
    localparam int ST_G = 6;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stage_en;

    utce_pkg::t_stage_a r_sa, n_sa;
    utce_pkg::t_stage_b r_sb, n_sb;
    utce_pkg::t_stage_c r_sc, n_sc;
    utce_pkg::t_stage_d r_sd, n_sd;
    utce_pkg::t_stage_e r_se, n_se;
    utce_pkg::t_stage_f r_sf, n_sf;
    utce_pkg::t_stage_g r_sg, n_sg;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when empty or when the next one moves
    // ------------------------------------------------------------------
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_stall = !stage_en[ST_A];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[ST_A]) r_vld[ST_A] <= i_valid;
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: second -> minute -> hour -> day carries, month -> year
    // ------------------------------------------------------------------
    always_comb begin
        logic       sec_c;
        logic       min_c;
        logic       hour_c;
        logic       mon_c;
        logic [6:0] min_sum;
        logic [5:0] hour_sum;
        sec_c       = i_second >= 6'(utce_pkg::SEC_PER_MIN);
        n_sa.tm.sec = sec_c ? i_second - 6'(utce_pkg::SEC_PER_MIN) : i_second;
        min_sum     = {1'b0, i_minute} + {6'b0, sec_c};
        min_c       = min_sum >= 7'(utce_pkg::MIN_PER_HOUR);
        n_sa.tm.min = min_c ? 6'(min_sum - 7'(utce_pkg::MIN_PER_HOUR)) : min_sum[5:0];
        hour_sum    = {1'b0, i_hour} + {5'b0, min_c};
        hour_c      = hour_sum >= 6'(utce_pkg::HOUR_PER_DAY);
        n_sa.tm.hour = hour_c ? 5'(hour_sum - 6'(utce_pkg::HOUR_PER_DAY)) : hour_sum[4:0];
        // zero-based day, day zero becomes -1
        n_sa.day    = $signed({1'b0, i_day_of_month} - 6'd1 + {5'b0, hour_c});
        mon_c       = i_month >= 4'(utce_pkg::MON_PER_YEAR);
        n_sa.month  = mon_c ? i_month - 4'(utce_pkg::MON_PER_YEAR) : i_month;
        n_sa.year   = {1'b0, i_year} + {12'b0, mon_c};
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_A]) r_sa <= n_sa;
    end

    // ------------------------------------------------------------------
    // Stage B: leap flags of this year and the one before, time of day
    // ------------------------------------------------------------------
    always_comb begin
        logic [12:0] y_prev;
        y_prev         = r_sa.year - 13'd1;
        n_sb.tm        = r_sa.tm;
        n_sb.day       = r_sa.day;
        n_sb.month     = r_sa.month;
        n_sb.year      = r_sa.year;
        n_sb.leap_cur  = utce_pkg::is_leap(r_sa.year);
        // year zero steps back to year -1, which is common
        n_sb.leap_prev = (r_sa.year != 13'd0) && utce_pkg::is_leap(y_prev);
        n_sb.tod       = {12'b0, r_sa.tm.hour} * 17'(utce_pkg::SEC_PER_HOUR)
                       + {11'b0, r_sa.tm.min} * 17'(utce_pkg::SEC_PER_MIN)
                       + {11'b0, r_sa.tm.sec};
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_B]) r_sb <= n_sb;
    end

    // ------------------------------------------------------------------
    // Stage C: borrow into the previous month or roll into the next
    // ------------------------------------------------------------------
    always_comb begin
        logic [4:0]         len_cur;
        logic [4:0]         len_prev;
        logic [4:0]         day_u;
        logic signed [13:0] y_s;
        y_s      = $signed({1'b0, r_sb.year});
        len_cur  = utce_pkg::month_len(r_sb.month, r_sb.leap_cur);
        len_prev = utce_pkg::month_len(r_sb.month - 4'd1, r_sb.leap_cur);
        day_u    = r_sb.day[4:0];
        n_sc.tm  = r_sb.tm;
        n_sc.tod = r_sb.tod;
        n_sc.year  = y_s;
        n_sc.month = r_sb.month;
        n_sc.day   = day_u;
        n_sc.leap  = r_sb.leap_cur;
        if (r_sb.day[5]) begin
            // day zero: last day of the previous month
            if (r_sb.month == utce_pkg::MONTH_JAN) begin
                n_sc.month = utce_pkg::MONTH_DEC;
                n_sc.year  = y_s - 14'sd1;
                n_sc.day   = utce_pkg::month_len(utce_pkg::MONTH_DEC, 1'b0) - 5'd1;
                n_sc.leap  = r_sb.leap_prev;
            end else begin
                n_sc.month = r_sb.month - 4'd1;
                n_sc.day   = len_prev - 5'd1;
            end
        end else if (day_u >= len_cur) begin
            // past month end
            n_sc.day = day_u - len_cur;
            if (r_sb.month == utce_pkg::MONTH_DEC) begin
                n_sc.month = utce_pkg::MONTH_JAN;
                n_sc.year  = y_s + 14'sd1;
                n_sc.leap  = 1'b0;
            end else begin
                n_sc.month = r_sb.month + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_C]) r_sc <= n_sc;
    end

    // ------------------------------------------------------------------
    // Stage D: day of year; leap-count quotients (truncating) and 365*dy
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [13:0] t4;
        logic signed [13:0] t100;
        logic signed [13:0] t400;
        logic signed [13:0] dy;
        logic [13:0]        a4;
        logic [13:0]        a100;
        logic [13:0]        a400;
        logic [24:0]        p100;
        logic [24:0]        p400;
        logic [9:0]         m4;
        logic [5:0]         m100;
        logic [3:0]         m400;
        logic signed [20:0] dy_x;
        t4   = r_sc.year - 14'(utce_pkg::LEAP4_BASE);
        t100 = r_sc.year - 14'(utce_pkg::LEAP100_BASE);
        t400 = r_sc.year - 14'(utce_pkg::LEAP400_BASE);
        dy   = r_sc.year - 14'(utce_pkg::EPOCH_YEAR);
        a4   = t4[13]   ? 14'(-t4)   : 14'(t4);
        a100 = t100[13] ? 14'(-t100) : 14'(t100);
        a400 = t400[13] ? 14'(-t400) : 14'(t400);
        p100 = {13'b0, a100[11:0]} * 25'(utce_pkg::RECIP_100);
        p400 = {13'b0, a400[11:0]} * 25'(utce_pkg::RECIP_100);
        m4   = a4[11:2];
        m100 = p100[utce_pkg::SHIFT_100 +: 6];
        m400 = p400[utce_pkg::SHIFT_400 +: 4];
        n_sd.q4   = t4[13]   ? -$signed({1'b0, m4})   : $signed({1'b0, m4});
        n_sd.q100 = t100[13] ? -$signed({1'b0, m100}) : $signed({1'b0, m100});
        n_sd.q400 = t400[13] ? -$signed({1'b0, m400}) : $signed({1'b0, m400});
        dy_x      = $signed({{7{dy[13]}}, dy});
        n_sd.m365 = dy_x * $signed(21'(utce_pkg::DAYS_PER_YEAR));
        n_sd.yday = {4'b0, r_sc.day} + utce_pkg::cum_days(r_sc.month)
                  + {8'b0, (r_sc.month > utce_pkg::MONTH_FEB) && r_sc.leap};
        n_sd.tm    = r_sc.tm;
        n_sd.tod   = r_sc.tod;
        n_sd.year  = r_sc.year;
        n_sd.month = r_sc.month;
        n_sd.day   = r_sc.day;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_D]) r_sd <= n_sd;
    end

    // ------------------------------------------------------------------
    // Stage E: signed day count since 1970
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [20:0] q4_x;
        logic signed [20:0] q100_x;
        logic signed [20:0] q400_x;
        q4_x   = $signed({{10{r_sd.q4[10]}}, r_sd.q4});
        q100_x = $signed({{14{r_sd.q100[6]}}, r_sd.q100});
        q400_x = $signed({{16{r_sd.q400[4]}}, r_sd.q400});
        n_se.days    = $signed({12'b0, r_sd.yday}) + r_sd.m365 + q4_x - q100_x + q400_x;
        n_se.invalid = r_sd.year < $signed(14'(utce_pkg::EPOCH_YEAR));
        n_se.tm    = r_sd.tm;
        n_se.tod   = r_sd.tod;
        n_se.year  = r_sd.year;
        n_se.month = r_sd.month;
        n_se.day   = r_sd.day;
        n_se.yday  = r_sd.yday;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_E]) r_se <= n_se;
    end

    // ------------------------------------------------------------------
    // Stage F: seconds of whole days; weekday operand of the 32-bit count
    // ------------------------------------------------------------------
    always_comb begin
        logic [36:0]        prod;
        logic signed [21:0] w;
        logic               wrapped;
        prod = {17'b0, r_se.days[19:0]} * 37'(utce_pkg::SEC_PER_DAY);
        // the unsigned count wrapped and count + 4 did not wrap back
        wrapped = r_se.days < -21'sd4;
        w = $signed({r_se.days[20], r_se.days}) + 22'(utce_pkg::WDAY_LIFT)
          + 22'(utce_pkg::EPOCH_WDAY)
          + (wrapped ? 22'(utce_pkg::WRAP_MOD7) : 22'sd0);
        n_sf.day_secs = prod[31:0];
        n_sf.wday_arg = w[20:0];
        n_sf.invalid  = r_se.invalid;
        n_sf.tm    = r_se.tm;
        n_sf.tod   = r_se.tod;
        n_sf.year  = r_se.year;
        n_sf.month = r_se.month;
        n_sf.day   = r_se.day;
        n_sf.yday  = r_se.yday;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_F]) r_sf <= n_sf;
    end

    // ------------------------------------------------------------------
    // Stage G: epoch seconds and weekday into the output register
    // ------------------------------------------------------------------
    always_comb begin
        n_sg.epoch   = r_sf.invalid ? '1 : r_sf.day_secs + {15'b0, r_sf.tod};
        n_sg.invalid = r_sf.invalid;
        n_sg.wday    = utce_pkg::mod7(r_sf.wday_arg);
        n_sg.year    = r_sf.year[11:0];
        n_sg.month   = r_sf.month;
        n_sg.day     = r_sf.day + 5'd1;
        n_sg.hour    = r_sf.tm.hour;
        n_sg.min     = r_sf.tm.min;
        n_sg.sec     = r_sf.tm.sec;
        n_sg.yday    = r_sf.yday;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_G]) r_sg <= n_sg;
    end

    assign o_valid         = r_vld[ST_G];
    assign o_epoch_seconds = r_sg.epoch;
    assign o_invalid       = r_sg.invalid;
    assign o_norm_year     = r_sg.year;
    assign o_norm_month    = r_sg.month;
    assign o_norm_day      = r_sg.day;
    assign o_norm_hour     = r_sg.hour;
    assign o_norm_minute   = r_sg.min;
    assign o_norm_second   = r_sg.sec;
    assign o_year_day      = r_sg.yday;
    assign o_week_day      = r_sg.wday;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // upstream is held off only when every stage holds a beat
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("stall raised with an empty stage");

    // an early year always reports all ones
    a_invalid_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_epoch_seconds == 32'hFFFF_FFFF))
        else $error("invalid result without all-ones epoch");

    // normalised clock fields are in range
    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_norm_second < 6'd60) && (o_norm_minute < 6'd60)
                     && (o_norm_hour < 5'd24) && (o_norm_month < 4'd12)))
        else $error("normalised time field out of range");

    // calendar fields are in range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_norm_day != 5'd0) && (o_year_day <= 9'd365)
                     && (o_week_day < 3'd7)))
        else $error("normalised date field out of range");

    // a full stage F moving into the output register raises o_valid
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_en[ST_G] && r_vld[ST_F]) |=> o_valid)
        else $error("beat lost on the way to the output");

endmodule
